// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// Source character tokenizer package
// Shared types, constants and helper functions of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  localparam int OffsetBits = 16;
  localparam int ValueBits  = 64;
  localparam int KwLen      = 6;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int MaxTokens  = 3;

  localparam logic [7:0] ChEq   = 8'h3D;
  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChZero = 8'h30;

  typedef enum logic [2:0] {
    KindNum     = 3'd0,
    KindIdent   = 3'd1,
    KindPunct   = 3'd2,
    KindKeyword = 3'd3,
    KindEnd     = 3'd4,
    KindError   = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeNum   = 3'd1,
    ModeIdent = 3'd2,
    ModeHeld  = 3'd3,
    ModeSkip  = 3'd4
  } mode_e;

  typedef struct packed {
    kind_e        kind;
    logic [15:0]  start;
    logic [15:0]  len;
    logic [63:0]  value;
    logic [15:0]  punct;
  } tok_t;

  typedef struct packed {
    logic [1:0]              count;
    tok_t [MaxTokens-1:0]    toks;
  } bundle_t;

  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h72;
      3'd1:    ch = 8'h65;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h75;
      3'd4:    ch = 8'h72;
      3'd5:    ch = 8'h6E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [15:0] off_field(input logic [OffsetBits-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[15:0];
  endfunction

  function automatic logic [63:0] val_field(input logic [ValueBits-1:0] v);
    return 64'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sct_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Scans one source byte per accepted transaction and builds the bundle of
// tokens that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_accept_i,
  input  wire logic [7:0]       char_byte_i,
  input  wire logic             end_of_input_i,
  output sct_pkg::bundle_t      bundle_o,
  output logic                  bundle_valid_o
);
  import sct_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] pstart_q, pstart_d;
  logic [OffsetBits-1:0] plen_q, plen_d;
  logic [ValueBits-1:0]  acc_q, acc_d;
  logic [2:0]            kwidx_q, kwidx_d;
  logic                  kwmis_q, kwmis_d;
  logic [7:0]            held_q, held_d;

  function automatic logic [OffsetBits-1:0] sat_inc(input logic [OffsetBits-1:0] v);
    return (v == {OffsetBits{1'b1}}) ? v : v + OffsetBits'(1);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic tok_t make_tok(input kind_e kind, input logic [15:0] start,
                                    input logic [15:0] len, input logic [63:0] value,
                                    input logic [15:0] punct);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.value = value;
    t.punct = punct;
    return t;
  endfunction

  always_comb begin
    logic [7:0]           c;
    logic [OffsetBits-1:0] pos;
    logic [1:0]           n;
    logic                 fresh;
    logic                 pend;
    logic [ValueBits+3:0] prod;
    tok_t                 ft;
    tok_t [2:0]           toks;

    c     = char_byte_i;
    pos   = pos_q;
    n     = 2'd0;
    fresh = 1'b1;
    pend  = 1'b0;
    prod  = '0;
    ft    = '0;
    toks  = '0;

    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    acc_d    = acc_q;
    kwidx_d  = kwidx_q;
    kwmis_d  = kwmis_q;
    held_d   = held_q;

    if (c == 8'd0) begin
      pend = 1'b1;
    end else begin
      if (mode_q != ModeSkip) begin
        unique case (mode_q)
          ModeHeld: begin
            if (c == ChEq) begin
              toks[n] = make_tok(KindPunct, off_field(pstart_q), 16'd2, '0, {held_q, ChEq});
              n       = n + 2'd1;
              mode_d  = ModeIdle;
              fresh   = 1'b0;
            end else begin
              toks[n] = make_tok(KindPunct, off_field(pstart_q), 16'd1, '0, {held_q, 8'h00});
              n       = n + 2'd1;
              mode_d  = ModeIdle;
            end
          end
          ModeNum: begin
            if (is_digit(c)) begin
              prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                     (ValueBits+4)'(c - ChZero);
              acc_d  = (prod[ValueBits+3:ValueBits] != 4'd0) ? {ValueBits{1'b1}} :
                       prod[ValueBits-1:0];
              plen_d = sat_inc(plen_q);
              fresh  = 1'b0;
            end else begin
              toks[n] = make_tok(KindNum, off_field(pstart_q), off_field(plen_q),
                                 val_field(acc_q), 16'h0000);
              n       = n + 2'd1;
              mode_d  = ModeIdle;
            end
          end
          ModeIdent: begin
            if (is_alpha(c) || is_digit(c)) begin
              if (!kwmis_q && kwidx_q < 3'(KwLen) && c == kw_char(kwidx_q)) begin
                kwidx_d = kwidx_q + 3'd1;
              end else begin
                kwmis_d = 1'b1;
              end
              plen_d = sat_inc(plen_q);
              fresh  = 1'b0;
            end else begin
              toks[n] = make_tok((!kwmis_q && kwidx_q == 3'(KwLen)) ? KindKeyword : KindIdent,
                                 off_field(pstart_q), off_field(plen_q), '0, 16'h0000);
              n       = n + 2'd1;
              mode_d  = ModeIdle;
            end
          end
          default: begin
          end
        endcase

        if (fresh) begin
          if (is_space(c)) begin
          end else if (is_digit(c)) begin
            mode_d   = ModeNum;
            pstart_d = pos;
            plen_d   = OffsetBits'(1);
            acc_d    = ValueBits'(c - ChZero);
          end else if (is_alpha(c)) begin
            mode_d   = ModeIdent;
            pstart_d = pos;
            plen_d   = OffsetBits'(1);
            kwidx_d  = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
            kwmis_d  = (c != kw_char(3'd0));
          end else if (is_punct(c)) begin
            if (c == ChEq || c == ChBang || c == ChLt || c == ChGt) begin
              mode_d   = ModeHeld;
              held_d   = c;
              pstart_d = pos;
              plen_d   = OffsetBits'(1);
            end else begin
              toks[n] = make_tok(KindPunct, off_field(pos), 16'd1, '0, {c, 8'h00});
              n       = n + 2'd1;
            end
          end else begin
            toks[n] = make_tok(KindError, off_field(pos), 16'd1, '0, 16'h0000);
            n       = n + 2'd1;
            mode_d  = ModeSkip;
          end
        end
      end
      pos_d = sat_inc(pos_q);
      pos   = pos_d;
      pend  = end_of_input_i;
    end

    if (pend) begin
      unique case (mode_d)
        ModeNum: ft = make_tok(KindNum, off_field(pstart_d), off_field(plen_d),
                               val_field(acc_d), 16'h0000);
        ModeIdent: ft = make_tok((!kwmis_d && kwidx_d == 3'(KwLen)) ? KindKeyword : KindIdent,
                                 off_field(pstart_d), off_field(plen_d), '0, 16'h0000);
        ModeHeld: ft = make_tok(KindPunct, off_field(pstart_d), 16'd1, '0, {held_d, 8'h00});
        default: ft = '0;
      endcase
      if (mode_d == ModeNum || mode_d == ModeIdent || mode_d == ModeHeld) begin
        toks[n] = ft;
        n       = n + 2'd1;
      end
      if (n != 2'd3) begin
        toks[n] = make_tok(KindEnd, off_field(pos), 16'd0, '0, 16'h0000);
        n       = n + 2'd1;
      end
      mode_d   = ModeIdle;
      pos_d    = '0;
      pstart_d = '0;
      plen_d   = '0;
      acc_d    = '0;
      kwidx_d  = 3'd0;
      kwmis_d  = 1'b0;
      held_d   = 8'h00;
    end

    bundle_o.count = n;
    bundle_o.toks  = toks;
    bundle_valid_o = in_accept_i && (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      acc_q    <= '0;
      kwidx_q  <= 3'd0;
      kwmis_q  <= 1'b0;
      held_q   <= 8'h00;
    end else if (in_accept_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      acc_q    <= acc_d;
      kwidx_q  <= kwidx_d;
      kwmis_q  <= kwmis_d;
      held_q   <= held_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sct_queue.sv =====
// ----------------------------------------------------------------------------
// Tokenizer bundle queue
// Short register queue that decouples the scanner from the token emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sct_pkg::bundle_t  push_data_i,
  input  wire logic              pop_i,
  output sct_pkg::bundle_t       head_o,
  output logic                   empty_o,
  output logic                   full_o
);
  import sct_pkg::*;

  bundle_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QueuePtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QueuePtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QueuePtrW+1)'(1);
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sct_back.sv =====
// ----------------------------------------------------------------------------
// Tokenizer back end
// Takes bundles from the queue and sends their tokens one per transaction
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sct_pkg::bundle_t  head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output sct_pkg::tok_t          tok_o,
  output logic                   m_tlast_o
);
  import sct_pkg::*;

  logic [1:0] sel_q, sel_d;
  logic       valid_q, valid_d;
  tok_t       tok_q, tok_d;
  logic       last_q, last_d;
  logic       load;

  always_comb begin
    load    = !empty_i && (!valid_q || m_tready_i);
    sel_d   = sel_q;
    valid_d = valid_q;
    tok_d   = tok_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      unique case (sel_q)
        2'd0:    tok_d = head_i.toks[0];
        2'd1:    tok_d = head_i.toks[1];
        2'd2:    tok_d = head_i.toks[2];
        default: tok_d = '0;
      endcase
      last_d  = (sel_q == head_i.count - 2'd1);
      valid_d = 1'b1;
      if (last_d) begin
        sel_d = 2'd0;
        pop_o = 1'b1;
      end else begin
        sel_d = sel_q + 2'd1;
      end
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  assign m_tvalid_o = valid_q;
  assign tok_o      = tok_q;
  assign m_tlast_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/source_char_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source character tokenizer
// Streaming lexer: source bytes in, number, identifier, keyword, punctuator,
// error and end tokens out.
// ----------------------------------------------------------------------------
// The slave channel takes one source byte per transaction in tdata, with
// tlast marking the final byte of a stream; a zero byte also ends a stream.
// The master channel sends one token per transaction: tuser holds the token
// kind and tlast marks the final token caused by one input byte.
// A byte is scanned in the cycle it is accepted and the tokens it causes go
// into a four-entry bundle queue. The first token reaches the output through
// the queue and then the output register. The block accepts one byte per
// cycle while the queue has space; the output register sends one token per
// cycle while the receiver is ready, so a byte that causes several tokens (at
// most three) holds the output until all of them are sent.
// When the receiver stalls, the output register holds its token, the queue
// fills and then tready drops until space frees up.
// Reset clears the scanner to the start of a new stream at offset zero and
// empties the queue and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module source_char_tokenizer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [7:0]    s_axis_tdata_i,   // char_byte
  input  wire logic          s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [111:0]       m_axis_tdata_o,   // start_offset, token_length,
                                               // number_value, punct_chars
  output logic [2:0]         m_axis_tuser_o,   // token_kind
  output logic               m_axis_tlast_o
);
  import sct_pkg::*;

  bundle_t bundle;
  bundle_t head;
  logic    bundle_valid;
  logic    empty;
  logic    full;
  logic    pop;
  logic    in_accept;
  tok_t    tok;

  assign s_axis_tready_o = !full;
  assign in_accept       = s_axis_tvalid_i && !full;

  sct_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_accept_i    (in_accept),
    .char_byte_i    (s_axis_tdata_i),
    .end_of_input_i (s_axis_tlast_i),
    .bundle_o       (bundle),
    .bundle_valid_o (bundle_valid)
  );

  sct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (bundle_valid),
    .push_data_i (bundle),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  sct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .tok_o      (tok),
    .m_tlast_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {tok.punct, tok.value, tok.len, tok.start};
  assign m_axis_tuser_o = tok.kind;

endmodule

`default_nettype wire

// ===== tb/source_char_tokenizer_check.sv =====
// ----------------------------------------------------------------------------
// Source character tokenizer checker
// Watches both stream channels, predicts the tokens of every accepted source
// byte and compares each sent token field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module source_char_tokenizer_check (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [7:0]   s_tdata_i,
  input  logic         s_tlast_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [111:0] m_tdata_i,
  input  logic [2:0]   m_tuser_i,
  input  logic         m_tlast_i,
  output int           errors_o,
  output int           outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sct_pkg::*;

  localparam logic [47:0] KeywordText = "return";

  typedef struct packed {
    tok_t tok;
    logic last;
  } token_exp_t;

  token_exp_t  token_fifo[$];

  mode_e       mode;
  logic [15:0] byte_pos;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [63:0] num_acc;
  logic [2:0]  kw_idx;
  logic        kw_miss;
  logic [7:0]  held_ch;

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word_start(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic is_punct_char(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void reset_stream();
    mode      = ModeIdle;
    byte_pos  = '0;
    tok_start = '0;
    tok_len   = '0;
    num_acc   = '0;
    kw_idx    = '0;
    kw_miss   = 1'b0;
    held_ch   = '0;
  endfunction

  function automatic void push_token(kind_e k, logic [15:0] st, logic [15:0] ln,
                                     logic [63:0] v, logic [15:0] p);
    token_exp_t e;
    e.tok.kind  = k;
    e.tok.start = st;
    e.tok.len   = ln;
    e.tok.value = v;
    e.tok.punct = p;
    e.last      = 1'b0;
    token_fifo.push_back(e);
  endfunction

  function automatic void flush_token();
    case (mode)
      ModeNum: begin
        push_token(KindNum, tok_start, tok_len, num_acc, 16'h0000);
      end
      ModeIdent: begin
        if (!kw_miss && kw_idx == KwLen) begin
          push_token(KindKeyword, tok_start, tok_len, 64'd0, 16'h0000);
        end else begin
          push_token(KindIdent, tok_start, tok_len, 64'd0, 16'h0000);
        end
      end
      ModeHeld: begin
        push_token(KindPunct, tok_start, 16'd1, 64'd0, {held_ch, 8'h00});
      end
      default: begin
      end
    endcase
    if (mode != ModeSkip) mode = ModeIdle;
  endfunction

  function automatic void ident_char(logic [7:0] c);
    if (!kw_miss && kw_idx < KwLen && c == KeywordText[8*(5-int'(kw_idx)) +: 8]) begin
      kw_idx = kw_idx + 3'd1;
    end else begin
      kw_miss = 1'b1;
    end
    tok_len = sat_inc(tok_len);
  endfunction

  function automatic void scan_char(logic [7:0] c, logic [15:0] at);
    logic [63:0] d;
    d = 64'(c - ChZero);
    if (mode == ModeHeld) begin
      if (c == ChEq) begin
        push_token(KindPunct, tok_start, 16'd2, 64'd0, {held_ch, ChEq});
        mode = ModeIdle;
        return;
      end
      flush_token();
    end else if (mode == ModeNum) begin
      if (is_digit(c)) begin
        if (num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
          num_acc = 64'hFFFF_FFFF_FFFF_FFFF;
        end else begin
          num_acc = num_acc * 64'd10 + d;
        end
        tok_len = sat_inc(tok_len);
        return;
      end
      flush_token();
    end else if (mode == ModeIdent) begin
      if (is_word_start(c) || is_digit(c)) begin
        ident_char(c);
        return;
      end
      flush_token();
    end

    if (is_blank(c)) return;
    if (is_digit(c)) begin
      mode      = ModeNum;
      tok_start = at;
      tok_len   = 16'd1;
      num_acc   = d;
    end else if (is_word_start(c)) begin
      mode      = ModeIdent;
      tok_start = at;
      tok_len   = 16'd0;
      kw_idx    = 3'd0;
      kw_miss   = 1'b0;
      ident_char(c);
    end else if (is_punct_char(c)) begin
      if (c == ChEq || c == ChBang || c == ChLt || c == ChGt) begin
        mode      = ModeHeld;
        held_ch   = c;
        tok_start = at;
        tok_len   = 16'd1;
      end else begin
        push_token(KindPunct, at, 16'd1, 64'd0, {c, 8'h00});
      end
    end else begin
      push_token(KindError, at, 16'd1, 64'd0, 16'h0000);
      mode = ModeSkip;
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic last);
    int          prior_size;
    logic [15:0] at;
    token_exp_t  e;
    prior_size = token_fifo.size();
    at         = byte_pos;
    if (c == 8'h00) begin
      flush_token();
      push_token(KindEnd, at, 16'd0, 64'd0, 16'h0000);
      reset_stream();
    end else begin
      if (mode != ModeSkip) scan_char(c, at);
      byte_pos = sat_inc(at);
      if (last) begin
        flush_token();
        push_token(KindEnd, byte_pos, 16'd0, 64'd0, 16'h0000);
        reset_stream();
      end
    end
    if (token_fifo.size() > prior_size) begin
      e = token_fifo[token_fifo.size()-1];
      e.last = 1'b1;
      token_fifo[token_fifo.size()-1] = e;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_exp_t e;
    if (!rst_ni) begin
      reset_stream();
      token_fifo.delete();
      errors_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (token_fifo.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual kind %0d data %0h",
                   $time, m_tuser_i, m_tdata_i);
          errors_o++;
        end else begin
          e = token_fifo.pop_front();
          check_field("token_kind", 64'(e.tok.kind), 64'(m_tuser_i));
          check_field("start_offset", 64'(e.tok.start), 64'(m_tdata_i[15:0]));
          check_field("token_length", 64'(e.tok.len), 64'(m_tdata_i[31:16]));
          check_field("number_value", e.tok.value, m_tdata_i[95:32]);
          check_field("punct_chars", 64'(e.tok.punct), 64'(m_tdata_i[111:96]));
          check_field("last_of_run", 64'(e.last), 64'(m_tlast_i));
        end
      end
      if (s_tvalid_i && s_tready_i) tokenize_byte(s_tdata_i, s_tlast_i);
    end
    outstanding_o = token_fifo.size();
  end

endmodule

// ===== tb/source_char_tokenizer_test.sv =====
// ----------------------------------------------------------------------------
// Source character tokenizer testbench
// Feeds directed and random source streams with random idling on both
// channels, including a long receiver stall, and reports the checker verdict.
// ----------------------------------------------------------------------------

module source_char_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sct_pkg::*;

  localparam logic [47:0] KeywordText = "return";

  logic         clk      = 1'b0;
  logic         rst_n    = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = 8'h00;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  int           errors;
  int           outstanding;

  bit           burst        = 1'b0;
  bit           hold_request = 1'b0;
  logic [7:0]   src_text[$];
  logic         src_last;
  int           random_items = 0;

  always #6 clk = ~clk;

  source_char_tokenizer i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  source_char_tokenizer_check i_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tlast_i     (s_tlast),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .m_tlast_i     (m_tlast),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  function automatic logic [7:0] word_char(bit with_digits);
    int unsigned r;
    r = $urandom_range(0, with_digits ? 62 : 52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return 8'h5F;
    return 8'(ChZero + r - 53);
  endfunction

  function automatic logic [7:0] held_char();
    case ($urandom_range(0, 3))
      0:       return ChEq;
      1:       return ChBang;
      2:       return ChLt;
      default: return ChGt;
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 5) == 5) return 8'd32;
    return 8'(9 + $urandom_range(0, 4));
  endfunction

  task automatic send_byte(logic [7:0] ch, logic last);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(string s, logic last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && i == s.len() - 1);
  endtask

  task automatic build_stream();
    int unsigned len;
    int unsigned r;
    src_text.delete();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
          repeat (len) src_text.push_back(8'(ChZero + $urandom_range(0, 9)));
        end
        3, 4: begin
          r   = $urandom_range(0, 3);
          len = (r < 2) ? 6 : (r == 2) ? $urandom_range(1, 5) : 0;
          for (int i = 0; i < len; i++) src_text.push_back(KeywordText[8*(5-i) +: 8]);
          if (r == 1) src_text.push_back(word_char(1'b1));
          if (r == 3) begin
            src_text.push_back(word_char(1'b0));
            repeat ($urandom_range(0, 5)) src_text.push_back(word_char(1'b1));
          end
        end
        5, 6: begin
          r = $urandom_range(0, 2);
          if (r == 0) begin
            src_text.push_back(held_char());
            src_text.push_back(ChEq);
          end else if (r == 1) begin
            src_text.push_back(held_char());
          end else begin
            r = $urandom_range(0, 31);
            if (r < 15) src_text.push_back(8'(33 + r));
            else if (r < 22) src_text.push_back(8'(58 + r - 15));
            else if (r < 28) src_text.push_back(8'(91 + r - 22));
            else src_text.push_back(8'(123 + r - 28));
          end
        end
        7: begin
          case ($urandom_range(0, 3))
            0:       src_text.push_back(8'($urandom_range(128, 255)));
            1:       src_text.push_back(8'($urandom_range(1, 8)));
            2:       src_text.push_back(8'($urandom_range(14, 31)));
            default: src_text.push_back(8'd127);
          endcase
        end
        8: begin
          src_text.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          src_text.push_back(blank_char());
        end
      endcase
      if ($urandom_range(0, 1) == 1) src_text.push_back(blank_char());
    end
    r = $urandom_range(0, 2);
    if (r != 1) src_text.push_back(8'h00);
    src_last = (r != 0);
  endtask

  initial begin : receiver
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_text("return", 1'b1);
    send_text("a<b>=7!", 1'b1);
    send_text("==", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h39, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h71, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h01, 1'b1);

    burst        = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_byte(8'h2C, 1'b0);
    send_byte(8'h00, 1'b0);

    repeat (22) send_byte(8'h39, 1'b0);
    send_text("x ", 1'b0);
    send_byte(8'h00, 1'b0);
    burst = 1'b0;

    while (random_items < 190) begin
      build_stream();
      burst = ($urandom_range(0, 5) == 0);
      foreach (src_text[i]) send_byte(src_text[i], src_last && i == src_text.size() - 1);
      random_items += src_text.size();
    end
    burst = 1'b0;
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
